@@ hw/rtl/adpcm_bd_pkg.sv @@
// ----------------------------------------------------------------------------
// adpcm block decoder package
// shared constants, the command word passed from front to back, and the
// predictor coefficient tables
// ----------------------------------------------------------------------------
package adpcm_bd_pkg;

  localparam int SAMPLES_PER_BLOCK = 28;
  localparam int BYTES_PER_BLOCK   = SAMPLES_PER_BLOCK / 2 + 2;
  localparam int POS_W             = $clog2(BYTES_PER_BLOCK);

  localparam logic [POS_W-1:0] POS_HEADER = POS_W'(0);
  localparam logic [POS_W-1:0] POS_FLAGS  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(BYTES_PER_BLOCK - 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int COEF_W      = 8;
  localparam int PROD_W      = 16 + COEF_W;
  localparam int COEF_SHIFT  = 6;
  localparam int SUM_W       = 20;

  typedef struct packed {
    logic [3:0] nib_lo;
    logic [3:0] nib_hi;
    logic [3:0] filter;
    logic [3:0] shift;
    logic [7:0] flags;
    logic       eob;
  } cmd_t;

  function automatic logic signed [COEF_W-1:0] coef_newer(input logic [3:0] filter);
    logic signed [COEF_W-1:0] c;
    case (filter)
      4'd1:    c = COEF_W'(60);
      4'd2:    c = COEF_W'(115);
      4'd3:    c = COEF_W'(98);
      4'd4:    c = COEF_W'(122);
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] coef_older(input logic [3:0] filter);
    logic signed [COEF_W-1:0] c;
    case (filter)
      4'd2:    c = -COEF_W'(52);
      4'd3:    c = -COEF_W'(55);
      4'd4:    c = -COEF_W'(60);
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/adpcm_bd_front.sv @@
// ----------------------------------------------------------------------------
// adpcm block decoder front end
// tracks the byte position in the block, latches header and flags, and turns
// each data byte into a command for the back end
// ----------------------------------------------------------------------------
module adpcm_bd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  output logic                push,
  output adpcm_bd_pkg::cmd_t  push_cmd,
  input  logic                q_full
);

  logic [adpcm_bd_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [3:0]                     filter_r, filter_nxt;
  logic [3:0]                     shift_r, shift_nxt;
  logic [7:0]                     flags_r, flags_nxt;
  logic                           accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    pos_nxt    = pos_r;
    filter_nxt = filter_r;
    shift_nxt  = shift_r;
    flags_nxt  = flags_r;
    push       = 1'b0;
    if (accept) begin
      pos_nxt = (pos_r == adpcm_bd_pkg::POS_LAST) ? adpcm_bd_pkg::POS_HEADER
                                                   : pos_r + 1'b1;
      if (pos_r == adpcm_bd_pkg::POS_HEADER) begin
        filter_nxt = in_data_byte[7:4];
        shift_nxt  = in_data_byte[3:0];
      end else if (pos_r == adpcm_bd_pkg::POS_FLAGS) begin
        flags_nxt = in_data_byte;
      end else begin
        push = 1'b1;
      end
    end
  end

  always_comb begin
    push_cmd.nib_lo = in_data_byte[3:0];
    push_cmd.nib_hi = in_data_byte[7:4];
    push_cmd.filter = filter_r;
    push_cmd.shift  = shift_r;
    push_cmd.flags  = flags_r;
    push_cmd.eob    = (pos_r == adpcm_bd_pkg::POS_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= adpcm_bd_pkg::POS_HEADER;
      filter_r <= '0;
      shift_r  <= '0;
      flags_r  <= '0;
    end else begin
      pos_r    <= pos_nxt;
      filter_r <= filter_nxt;
      shift_r  <= shift_nxt;
      flags_r  <= flags_nxt;
    end
  end

endmodule

@@ hw/rtl/adpcm_bd_queue.sv @@
// ----------------------------------------------------------------------------
// adpcm block decoder command queue
// small fifo between the front end and the back end
// ----------------------------------------------------------------------------
module adpcm_bd_queue #(
  parameter int DEPTH = adpcm_bd_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  adpcm_bd_pkg::cmd_t  push_cmd,
  output logic                full,
  input  logic                pop,
  output adpcm_bd_pkg::cmd_t  pop_cmd,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  adpcm_bd_pkg::cmd_t mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ hw/rtl/adpcm_bd_back.sv @@
// ----------------------------------------------------------------------------
// adpcm block decoder back end
// decodes the two nibbles of each command through one multiply stage and one
// add/saturate stage, keeps the two history taps, drives the output register
// ----------------------------------------------------------------------------
module adpcm_bd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  adpcm_bd_pkg::cmd_t  pop_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_sample,
  output logic [7:0]          out_block_flags,
  output logic                out_last_of_run,
  output logic                out_end_of_block
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ADD  = 2'd2;

  localparam int PW = adpcm_bd_pkg::PROD_W;
  localparam int SW = adpcm_bd_pkg::SUM_W;

  logic [1:0]                 state_r, state_nxt;
  logic                       k_r, k_nxt;
  adpcm_bd_pkg::cmd_t         cur_r;
  logic signed [15:0]         newer_r, older_r;
  logic signed [PW-1:0]       p0_r, p1_r;
  logic signed [15:0]         scaled_r;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [15:0]         out_sample_r;
  logic [7:0]                 out_flags_r;
  logic                       out_last_r, out_eob_r;

  logic [3:0]                 nib;
  logic signed [15:0]         nib_ext;
  logic signed [PW-1:0]       p0_nxt, p1_nxt;
  logic signed [SW-1:0]       sum;
  logic signed [15:0]         sat;
  logic                       slot_free;
  logic                       emit;

  assign nib     = k_r ? cur_r.nib_hi : cur_r.nib_lo;
  assign nib_ext = {nib, 12'b0};
  assign p0_nxt  = newer_r * adpcm_bd_pkg::coef_newer(cur_r.filter);
  assign p1_nxt  = older_r * adpcm_bd_pkg::coef_older(cur_r.filter);

  assign sum = SW'(scaled_r)
             + SW'(p0_r >>> adpcm_bd_pkg::COEF_SHIFT)
             + SW'(p1_r >>> adpcm_bd_pkg::COEF_SHIFT);

  always_comb begin
    if (sum > SW'(32767)) begin
      sat = 16'sh7fff;
    end else if (sum < -SW'(32768)) begin
      sat = -16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = (state_r == ST_IDLE) && !q_empty;
  assign emit      = (state_r == ST_ADD) && slot_free;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = ST_MUL;
          k_nxt     = 1'b0;
        end
      end
      ST_MUL: begin
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (k_r) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = 1'b1;
            state_nxt = ST_MUL;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_cmd;
    end
    if (state_r == ST_MUL) begin
      p0_r     <= p0_nxt;
      p1_r     <= p1_nxt;
      scaled_r <= nib_ext >>> cur_r.shift;
    end
    if (emit) begin
      out_sample_r <= sat;
      out_flags_r  <= cur_r.flags;
      out_last_r   <= k_r;
      out_eob_r    <= k_r && cur_r.eob;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= 1'b0;
      out_valid_r <= 1'b0;
      newer_r     <= '0;
      older_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (emit) begin
        older_r <= newer_r;
        newer_r <= sat;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample       = out_sample_r;
  assign out_block_flags  = out_flags_r;
  assign out_last_of_run  = out_last_r;
  assign out_end_of_block = out_eob_r;

endmodule

@@ hw/rtl/adpcm_block_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// adpcm block decoder unit
// decodes 16-byte adpcm sound blocks into signed 16-bit samples
// ----------------------------------------------------------------------------
// Bytes enter one per transaction: a header byte (filter, shift), a flags byte,
// then 14 data bytes that each give two samples, low nibble first. Header and
// flags bytes give no output. A data byte is queued as a command and decoded
// by a single multiply/add datapath: the idle state picks up the command, then
// a multiply state and an add/saturate state follow per sample, and the add
// state waits while the output register is stalled. The second sample waits on
// the history update of the first. The command queue (QUEUE_DEPTH entries) lets
// the input side run ahead by that many data bytes; the output register holds a
// sample while out_stall is high. History taps carry across blocks; filter and
// shift are reloaded from each header byte.
module adpcm_block_decoder_unit #(
  parameter int QUEUE_DEPTH = adpcm_bd_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_data_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic [7:0]         out_block_flags,
  output logic               out_last_of_run,
  output logic               out_end_of_block
);

  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  adpcm_bd_pkg::cmd_t push_cmd;
  adpcm_bd_pkg::cmd_t pop_cmd;

  adpcm_bd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .push         (push),
    .push_cmd     (push_cmd),
    .q_full       (q_full)
  );

  adpcm_bd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  adpcm_bd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .pop_cmd          (pop_cmd),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_block_flags  (out_block_flags),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_block (out_end_of_block)
  );

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adpcm block decoder unit testbench
// streams header, flags and data bytes into the decoder while a tracker
// predicts every decoded sample, with random idle and stall on both channels
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_PER_PHASE = 331;
  localparam int WATCHDOG_LIMIT   = 5000;
  localparam int DRAIN_CYCLES     = 20;

  localparam int NEWER_TAP [5] = '{0, 60, 115, 98, 122};
  localparam int OLDER_TAP [5] = '{0, 0, -52, -55, -60};

  localparam logic [7:0] OPENING_BYTES [25] = '{
    8'h40, 8'hff,
    8'h77, 8'h77, 8'h77, 8'h77, 8'h88, 8'h88, 8'h88, 8'h88,
    8'h00, 8'hff, 8'h80, 8'h08, 8'h7f, 8'hf7,
    8'hff, 8'h00,
    8'h80, 8'h08, 8'hff, 8'h77, 8'h00, 8'h88, 8'h7f
  };

  typedef struct {
    logic signed [15:0] sample;
    logic [7:0]         flags;
    logic               last_of_run;
    logic               end_of_block;
  } decoded_sample_t;

  class decoded_sample_tracker;
    decoded_sample_t    expected_samples[$];
    int                 errors = 0;
    logic [3:0]         filter = '0;
    logic [3:0]         shift = '0;
    logic [7:0]         flags = '0;
    logic [3:0]         position = adpcm_bd_pkg::POS_HEADER;
    logic signed [15:0] older = '0;
    logic signed [15:0] newer = '0;

    function logic signed [15:0] predict_nibble(input logic [3:0] nib);
      int scaled;
      int tap_new;
      int tap_old;
      int acc;
      scaled = int'($signed({nib, 12'h000}));
      tap_new = 0;
      tap_old = 0;
      if (filter < 5) begin
        tap_new = NEWER_TAP[filter];
        tap_old = OLDER_TAP[filter];
      end
      acc = (scaled >>> shift)
          + ((int'(newer) * tap_new) >>> adpcm_bd_pkg::COEF_SHIFT)
          + ((int'(older) * tap_old) >>> adpcm_bd_pkg::COEF_SHIFT);
      if (acc > 32767) acc = 32767;
      if (acc < -32768) acc = -32768;
      older = newer;
      newer = acc[15:0];
      return acc[15:0];
    endfunction

    function void note_byte(input logic [7:0] b);
      decoded_sample_t e;
      case (position)
        adpcm_bd_pkg::POS_HEADER: begin
          filter = b[7:4];
          shift = b[3:0];
        end
        adpcm_bd_pkg::POS_FLAGS: begin
          flags = b;
        end
        default: begin
          e.sample = predict_nibble(b[3:0]);
          e.flags = flags;
          e.last_of_run = 1'b0;
          e.end_of_block = 1'b0;
          expected_samples.push_back(e);
          e.sample = predict_nibble(b[7:4]);
          e.last_of_run = 1'b1;
          e.end_of_block = (position == adpcm_bd_pkg::POS_LAST);
          expected_samples.push_back(e);
        end
      endcase
      position = position + 1'b1;
    endfunction

    function void check_sample(input logic signed [15:0] sample, input logic [7:0] fl,
                               input logic last, input logic eob);
      decoded_sample_t e;
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample %0d flags %h last %b eob %b",
                 $time, sample, fl, last, eob);
        errors++;
        return;
      end
      e = expected_samples.pop_front();
      if (sample !== e.sample) begin
        $display("%0t: sample expected %0d actual %0d", $time, e.sample, sample);
        errors++;
      end
      if (fl !== e.flags) begin
        $display("%0t: block_flags expected %h actual %h", $time, e.flags, fl);
        errors++;
      end
      if (last !== e.last_of_run) begin
        $display("%0t: last_of_run expected %b actual %b", $time, e.last_of_run, last);
        errors++;
      end
      if (eob !== e.end_of_block) begin
        $display("%0t: end_of_block expected %b actual %b", $time, e.end_of_block, eob);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_data_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_sample;
  logic [7:0]         out_block_flags;
  logic               out_last_of_run;
  logic               out_end_of_block;

  decoded_sample_tracker tracker = new;
  logic [3:0] stream_pos = '0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         quiet_cycles = 0;

  adpcm_block_decoder_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_block_flags  (out_block_flags),
    .out_last_of_run  (out_last_of_run),
    .out_end_of_block (out_end_of_block)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_byte(b);
    stream_pos = stream_pos + 1'b1;
  endtask

  function automatic logic [7:0] random_stream_byte(input logic [3:0] at);
    logic [3:0] filt;
    logic [3:0] shamt;
    if (at == adpcm_bd_pkg::POS_HEADER) begin
      filt = ($urandom_range(9) < 8) ? 4'($urandom_range(4)) : 4'($urandom_range(15));
      shamt = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(12));
      return {filt, shamt};
    end
    if (at != adpcm_bd_pkg::POS_FLAGS && $urandom_range(7) == 0)
      return $urandom_range(1) ? 8'h77 : 8'h88;
    return 8'($urandom_range(255));
  endfunction

  // sample sink with random stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_sample(out_sample, out_block_flags, out_last_of_run, out_end_of_block);
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      repeat (RANDOM_PER_PHASE) send_byte(random_stream_byte(stream_pos));
    end
    in_valid <= 1'b0;
    while (tracker.expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ adpcm_block_decoder_unit.f @@
hw/rtl/adpcm_bd_pkg.sv
hw/rtl/adpcm_bd_front.sv
hw/rtl/adpcm_bd_queue.sv
hw/rtl/adpcm_bd_back.sv
hw/rtl/adpcm_block_decoder_unit.sv
bench/testbench.sv
